[src/pcr_pkg.sv]
// Package: widths, limits and the registered sample type for the PCR clock tracker.
`timescale 1ns / 1ps

package pcr_pkg;

  localparam int unsigned PID_W      = 13;
  localparam int unsigned BASE_W     = 33;
  localparam int unsigned EXT_W      = 9;
  localparam int unsigned WRAP_BITS  = 15;
  // running clock: PCR base with the wrap counter on top
  localparam int unsigned CLK_W      = BASE_W + WRAP_BITS;
  localparam int unsigned ELAPSED_W  = 48;

  localparam logic [EXT_W-1:0] EXT_MAX = EXT_W'(299);
  localparam logic [EXT_W-1:0] EXT_MOD = EXT_W'(300);

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [BASE_W-1:0] pcr_base;
    logic [EXT_W-1:0]  pcr_ext;
  } pcr_sample_t;

endpackage

[src/pcr_if.sv]
// Valid/ready channel interfaces for PCR samples and tracker results.
`timescale 1ns / 1ps

interface pcr_sample_if
  import pcr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PID_W-1:0]  pid;
  logic [BASE_W-1:0] pcr_base;
  logic [EXT_W-1:0]  pcr_ext;

  modport source (output valid, output pid, output pcr_base, output pcr_ext, input ready);
  modport sink   (input valid, input pid, input pcr_base, input pcr_ext, output ready);
endinterface

interface pcr_result_if
  import pcr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 taken;
  logic                 new_reference;
  logic                 wrapped;
  logic [ELAPSED_W-1:0] elapsed_base;
  logic [EXT_W-1:0]     elapsed_ext;

  modport source (output valid, output taken, output new_reference, output wrapped,
                  output elapsed_base, output elapsed_ext, input ready);
  modport sink   (input valid, input taken, input new_reference, input wrapped,
                  input elapsed_base, input elapsed_ext, output ready);
endinterface

[src/pcr_in_reg.sv]
// Input register: captures one sample beat and saturates the extension.
`timescale 1ns / 1ps

module pcr_in_reg
  import pcr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  pcr_sample_if.sink   sample_i,
  input  logic         advance_i,
  output logic         valid_o,
  output pcr_sample_t  sample_o
);

  logic        valid_q, valid_d;
  pcr_sample_t sample_q;
  logic        load;
  logic [EXT_W-1:0] ext_sat;

  // slot frees when empty or when the core consumes it this cycle
  assign sample_i.ready = !valid_q || advance_i;
  assign load           = sample_i.valid && sample_i.ready;
  assign ext_sat        = (sample_i.pcr_ext > EXT_MAX) ? EXT_MAX : sample_i.pcr_ext;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q.pid      <= sample_i.pid;
      sample_q.pcr_base <= sample_i.pcr_base;
      sample_q.pcr_ext  <= ext_sat;
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;

endmodule

[src/pcr_track_core.sv]
// Tracker core: reference lock, wrap extension, elapsed time and result register.
`timescale 1ns / 1ps

module pcr_track_core
  import pcr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  pcr_sample_t  sample_i,
  output logic         advance_o,
  pcr_result_if.source result_o
);

  logic              have_ref_q, have_ref_d;
  logic [PID_W-1:0]  ref_pid_q, ref_pid_d;
  logic              repeat_q, repeat_d;
  logic [CLK_W-1:0]  run_base_q, run_base_d;
  logic [EXT_W-1:0]  run_ext_q, run_ext_d;
  logic [BASE_W-1:0] start_base_q, start_base_d;
  logic [EXT_W-1:0]  start_ext_q, start_ext_d;

  logic                 out_valid_q, out_valid_d;
  logic                 taken_q, newref_q, wrapped_q;
  logic [ELAPSED_W-1:0] eb_q;
  logic [EXT_W-1:0]     ee_q;

  logic                 fire;
  logic                 match, wrap_det;
  logic [WRAP_BITS-1:0] wrap_cnt;
  logic                 taken_d, newref_d, wrapped_d;
  logic [CLK_W-1:0]     eb;
  logic [EXT_W-1:0]     ee;

  assign advance_o = !out_valid_q || result_o.ready;
  assign fire      = valid_i && advance_o;

  assign match    = have_ref_q && (sample_i.pid == ref_pid_q);
  assign wrap_det = sample_i.pcr_base < run_base_q[BASE_W-1:0];
  assign wrap_cnt = run_base_q[CLK_W-1:BASE_W] + WRAP_BITS'(wrap_det);

  always_comb begin
    have_ref_d   = have_ref_q;
    ref_pid_d    = ref_pid_q;
    repeat_d     = repeat_q;
    run_base_d   = run_base_q;
    run_ext_d    = run_ext_q;
    start_base_d = start_base_q;
    start_ext_d  = start_ext_q;
    taken_d      = 1'b0;
    newref_d     = 1'b0;
    wrapped_d    = 1'b0;
    if (match) begin
      repeat_d   = 1'b1;
      run_base_d = {wrap_cnt, sample_i.pcr_base};
      run_ext_d  = sample_i.pcr_ext;
      taken_d    = 1'b1;
      wrapped_d  = wrap_det;
    end else if (!repeat_q) begin
      // unlocked: any other PID takes over as reference
      have_ref_d   = 1'b1;
      ref_pid_d    = sample_i.pid;
      run_base_d   = CLK_W'(sample_i.pcr_base);
      run_ext_d    = sample_i.pcr_ext;
      start_base_d = sample_i.pcr_base;
      start_ext_d  = sample_i.pcr_ext;
      taken_d      = 1'b1;
      newref_d     = 1'b1;
    end
  end

  // elapsed time from the updated clock, borrow modulo 300 in the extension
  always_comb begin
    if (run_ext_d < start_ext_d) begin
      eb = run_base_d - CLK_W'(start_base_d) - CLK_W'(1);
      ee = EXT_MOD + run_ext_d - start_ext_d;
    end else begin
      eb = run_base_d - CLK_W'(start_base_d);
      ee = run_ext_d - start_ext_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_ref_q   <= 1'b0;
      ref_pid_q    <= '0;
      repeat_q     <= 1'b0;
      run_base_q   <= '0;
      run_ext_q    <= '0;
      start_base_q <= '0;
      start_ext_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        have_ref_q   <= have_ref_d;
        ref_pid_q    <= ref_pid_d;
        repeat_q     <= repeat_d;
        run_base_q   <= run_base_d;
        run_ext_q    <= run_ext_d;
        start_base_q <= start_base_d;
        start_ext_q  <= start_ext_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      taken_q   <= taken_d;
      newref_q  <= newref_d;
      wrapped_q <= wrapped_d;
      eb_q      <= ELAPSED_W'(eb);
      ee_q      <= ee;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.taken         = taken_q;
  assign result_o.new_reference = newref_q;
  assign result_o.wrapped       = wrapped_q;
  assign result_o.elapsed_base  = eb_q;
  assign result_o.elapsed_ext   = ee_q;

endmodule

[src/pcr_clock_tracker_unit.sv]
// Top level of the PCR clock tracker: input register feeding the tracker core.
//
// sample_i carries one PCR sample per beat (PID, 33-bit base, extension); an
// extension above 299 is treated as 299. result_o returns exactly one result
// beat per sample: taken, new_reference, wrapped and the time elapsed since
// the reference start (48-bit base, extension 0..299).
// The first sample sets the reference PID; another PID replaces it until the
// reference PID repeats, after which other PIDs are ignored. The running base
// is extended past its 33-bit wrap by a 15-bit wrap counter.
// A sample beat passes through the input register, then the result register,
// whose output is the result beat. The tracker accepts one sample per cycle
// while result_o does not stall; the clock state updates in the same cycle
// the result register loads.
// When result_o stalls, the result register holds and the input register
// absorbs one more beat; sample_i.ready then drops until result_o drains.
// Reset (rst_ni low, asynchronous) clears the reference, the lock, the
// running and start clocks and both valid flags; no result is pending.
`timescale 1ns / 1ps

module pcr_clock_tracker_unit
  import pcr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  pcr_sample_if.sink   sample_i,
  pcr_result_if.source result_o
);

  logic        stage_valid;
  logic        advance;
  pcr_sample_t stage_sample;

  pcr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_i),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .sample_o  (stage_sample)
  );

  pcr_track_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stage_valid),
    .sample_i  (stage_sample),
    .advance_o (advance),
    .result_o  (result_o)
  );

endmodule

[test/pcr_clock_tracker_unit_test.sv]
// Self-checking testbench for the PCR clock tracker: directed and random sample streams.
`timescale 1ns / 1ps

module pcr_clock_tracker_unit_test;
  import pcr_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned TRAFFIC_ITEMS = 330;
  // a run of descending bases, each one after the first a wrap
  localparam int unsigned WRAP_RUN      = 64;
  localparam logic [BASE_W-1:0] BASE_TOP = {BASE_W{1'b1}};

  typedef struct packed {
    logic                 taken;
    logic                 new_reference;
    logic                 wrapped;
    logic [ELAPSED_W-1:0] elapsed_base;
    logic [EXT_W-1:0]     elapsed_ext;
  } clock_reading_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pcr_sample_if sample_if ();
  pcr_result_if result_if ();

  pcr_clock_tracker_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  clock_reading_t expected_readings[$];
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // tracker state as seen from outside
  logic             have_ref     = 1'b0;
  logic             ref_repeated = 1'b0;
  logic [PID_W-1:0] ref_pid      = '0;
  logic [CLK_W-1:0] run_base     = '0;
  logic [CLK_W-1:0] origin_base  = '0;
  logic [EXT_W-1:0] run_ext      = '0;
  logic [EXT_W-1:0] origin_ext   = '0;

  function automatic clock_reading_t track_sample(input pcr_sample_t s);
    clock_reading_t   r;
    logic [EXT_W-1:0] ext;
    logic [CLK_W-1:0] span;
    r   = '0;
    ext = (s.pcr_ext > EXT_MAX) ? EXT_MAX : s.pcr_ext;
    if (have_ref && s.pid == ref_pid) begin
      ref_repeated = 1'b1;
      if (s.pcr_base < run_base[BASE_W-1:0]) begin
        run_base[BASE_W-1:0]     = '0;
        run_base[CLK_W-1:BASE_W] = run_base[CLK_W-1:BASE_W] + WRAP_BITS'(1);
        r.wrapped = 1'b1;
      end
      run_base[BASE_W-1:0] = s.pcr_base;
      run_ext = ext;
      r.taken = 1'b1;
    end else if (!ref_repeated) begin
      have_ref    = 1'b1;
      ref_pid     = s.pid;
      run_base    = CLK_W'(s.pcr_base);
      origin_base = CLK_W'(s.pcr_base);
      run_ext     = ext;
      origin_ext  = ext;
      r.taken         = 1'b1;
      r.new_reference = 1'b1;
    end
    span = run_base - origin_base;
    if (run_ext < origin_ext) begin
      span          = span - CLK_W'(1);
      r.elapsed_ext = EXT_MOD + run_ext - origin_ext;
    end else begin
      r.elapsed_ext = run_ext - origin_ext;
    end
    r.elapsed_base = ELAPSED_W'(span);
    return r;
  endfunction

  task automatic send_sample(input logic [PID_W-1:0] pid, input logic [BASE_W-1:0] base,
                             input logic [EXT_W-1:0] ext);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    sample_if.valid    <= 1'b1;
    sample_if.pid      <= pid;
    sample_if.pcr_base <= base;
    sample_if.pcr_ext  <= ext;
    do @(posedge clk_i); while (!sample_if.ready);
    expected_readings.push_back(track_sample({pid, base, ext}));
  endtask

  // stop sending and hold off until every outstanding reading has come back
  task automatic wait_for_readings();
    sample_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_readings.size() != 0);
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_readings
    clock_reading_t want;
    if (result_if.valid && result_if.ready) begin
      if (expected_readings.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat: expected none, got base 0x%0h ext %0d",
                 $time, result_if.elapsed_base, result_if.elapsed_ext);
      end else begin
        want = expected_readings.pop_front();
        compare_field("taken", 64'(want.taken), 64'(result_if.taken));
        compare_field("new_reference", 64'(want.new_reference),
                      64'(result_if.new_reference));
        compare_field("wrapped", 64'(want.wrapped), 64'(result_if.wrapped));
        compare_field("elapsed_base", 64'(want.elapsed_base),
                      64'(result_if.elapsed_base));
        compare_field("elapsed_ext", 64'(want.elapsed_ext), 64'(result_if.elapsed_ext));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("pcr_clock_tracker_unit test failed");
        $finish;
      end
    end
  end

  // before lock: every new PID takes over; saturation and borrow around the start
  task automatic test_reference_handover();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_sample(PID_W'(0), '0, '0);              // first sample at reset, PID 0
    send_sample(PID_W'(8191), BASE_TOP, EXT_W'(511));
    send_sample(PID_W'(5), BASE_W'(100), EXT_W'(300));
    // same PID, ext below start: borrow takes the base below zero, locks PID 5
    send_sample(PID_W'(5), BASE_W'(100), EXT_W'(0));
    wait_for_readings();
  endtask

  // after lock: other PIDs ignored, wraps and the no-wrap edge
  task automatic test_locked_clock();
    send_sample(PID_W'(5), BASE_W'(50), EXT_W'(299));
    send_sample(PID_W'(0), BASE_W'(7), EXT_W'(1));
    send_sample(PID_W'(8191), BASE_TOP, EXT_W'(299));
    send_sample(PID_W'(4), BASE_W'(0), EXT_W'(0));
    send_sample(PID_W'(5), BASE_TOP, EXT_W'(256));
    send_sample(PID_W'(5), '0, '0);
    send_sample(PID_W'(5), '0, EXT_W'(400));     // equal base: no wrap
    send_sample(PID_W'(5), BASE_W'(1), EXT_W'(150));
    send_sample(PID_W'(6), BASE_W'(1), EXT_W'(150));
    wait_for_readings();
  endtask

  // descending bases wrap on every beat after the first
  task automatic test_wrap_run();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int unsigned i = 0; i < WRAP_RUN; i++) begin
      send_sample(ref_pid, BASE_TOP - BASE_W'(i), EXT_W'($urandom_range(299)));
    end
    wait_for_readings();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input bit hold_midway);
    int unsigned       taken_sent;
    logic [PID_W-1:0]  pid;
    logic [BASE_W-1:0] base;
    logic [BASE_W-1:0] last;
    logic [EXT_W-1:0]  ext;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    taken_sent     = 0;
    while (taken_sent < TRAFFIC_ITEMS) begin
      pid  = ($urandom_range(3) == 0) ? PID_W'($urandom) : ref_pid;
      last = run_base[BASE_W-1:0];
      case ($urandom_range(7))
        0:       base = '0;
        1:       base = '1;
        2, 3:    base = last + BASE_W'($urandom_range(3000));
        4:       base = last - BASE_W'($urandom_range(1, 3000));
        default: base = BASE_W'({$urandom, $urandom});
      endcase
      ext = ($urandom_range(7) == 0) ? EXT_W'($urandom) : EXT_W'($urandom_range(299));
      if ((have_ref && pid == ref_pid) || !ref_repeated) taken_sent++;
      send_sample(pid, base, ext);
      if (hold_midway && taken_sent == TRAFFIC_ITEMS / 2) begin
        wait_for_readings();
        hold_midway = 1'b0;
      end
    end
    wait_for_readings();
  endtask

  initial begin
    sample_if.valid    <= 1'b0;
    sample_if.pid      <= '0;
    sample_if.pcr_base <= '0;
    sample_if.pcr_ext  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reference_handover();
    test_locked_clock();
    test_wrap_run();
    test_random_traffic(0, 0, 1'b0);
    test_random_traffic(64, 0, 1'b1);
    test_random_traffic(0, 64, 1'b0);
    test_random_traffic(12, 12, 1'b0);

    wait_for_readings();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("pcr_clock_tracker_unit test passed");
    end else begin
      $display("pcr_clock_tracker_unit test failed");
    end
    $finish;
  end

endmodule

[pcr_clock_tracker_unit.f]
src/pcr_pkg.sv
src/pcr_if.sv
src/pcr_in_reg.sv
src/pcr_track_core.sv
src/pcr_clock_tracker_unit.sv
test/pcr_clock_tracker_unit_test.sv
